// ===== rtl/qau_pkg.sv =====
`default_nettype none
package qau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int PW        = 2 * DW;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_QUOT = 4'd3,
    OP_SCL  = 4'd4,
    OP_SDIV = 4'd5,
    OP_NEG  = 4'd6,
    OP_CONJ = 4'd7,
    OP_DOT  = 4'd8,
    OP_NSQ  = 4'd9,
    OP_NORM = 4'd10,
    OP_INV  = 4'd11,
    OP_UNIT = 4'd12,
    OP_ROT  = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]            opcode;
    logic signed [DW-1:0]  a_w;
    logic signed [DW-1:0]  a_x;
    logic signed [DW-1:0]  a_y;
    logic signed [DW-1:0]  a_z;
    logic signed [DW-1:0]  b_w;
    logic signed [DW-1:0]  b_x;
    logic signed [DW-1:0]  b_y;
    logic signed [DW-1:0]  b_z;
  } qau_in_t;

  typedef struct packed {
    logic signed [DW-1:0]  res_w;
    logic signed [DW-1:0]  res_x;
    logic signed [DW-1:0]  res_y;
    logic signed [DW-1:0]  res_z;
    logic [1:0]            status;
  } qau_out_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DW-1:0] sat32(input logic signed [PW+7:0] v);
    logic signed [PW+7:0] mx;
    logic signed [PW+7:0] mn;
    mx = {{(PW+8-DW+1){1'b0}}, {(DW-1){1'b1}}};
    mn = ~mx;
    if (v > mx) sat32 = mx[DW-1:0];
    else if (v < mn) sat32 = mn[DW-1:0];
    else sat32 = v[DW-1:0];
  endfunction

  function automatic logic ovf32(input logic signed [PW+7:0] v);
    logic signed [PW+7:0] mx;
    logic signed [PW+7:0] mn;
    mx = {{(PW+8-DW+1){1'b0}}, {(DW-1){1'b1}}};
    mn = ~mx;
    ovf32 = (v > mx) || (v < mn);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/quaternion_arithmetic_unit.sv =====
`default_nettype none
// Channel   Ports                          Beat
// command   start, busy, cmd (qau_in_t)    opcode + quaternions a, b
// result    done, rsp (qau_out_t)          res_w..res_z + status
//
// Fully pipelined: one command beat per cycle, busy is always low.
// The command passes in order through 3 product/sum stages, 32 square-root
// steps, 64 divider steps, 2 stages for the second Hamilton product and
// 1 output register before done is raised.
// rst is synchronous, active high; it clears all valid bits.
// The receiver cannot stall: each result is on rsp for one cycle with done.
module quaternion_arithmetic_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  qau_pkg::qau_in_t        cmd,
  output logic                    done,
  output qau_pkg::qau_out_t       rsp
);
  import qau_pkg::*;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  qau_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .in_beat  (cmd),
    .out_vld  (done),
    .out_beat (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/qau_core.sv =====
`default_nettype none
// Pipelined datapath: one item per cycle. Stages are hamilton/dot multiply
// sums, a pipelined restoring divider and a pipelined sqrt.
// Sum of products rounding: sum exact at 2F frac bits, +half, floor.
module qau_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  qau_pkg::qau_in_t     in_beat,
  output logic                 out_vld,
  output qau_pkg::qau_out_t    out_beat
);
  import qau_pkg::*;

  localparam int AW  = PW + 8;          // accumulator width
  localparam int NW  = 64;              // divider numerator magnitude width
  localparam int DVW = 64;              // divisor magnitude width
  localparam int SQ  = 32;              // sqrt result bits
  localparam int NQ  = 4;

  typedef logic signed [DW-1:0] q_t;
  typedef q_t [NQ-1:0] quat_t;
  typedef logic signed [AW-1:0] acc_t;

  // ---------------- helpers ----------------
  function automatic acc_t prod(input q_t x, input q_t y);
    logic signed [PW-1:0] p;
    p = x * y;
    prod = AW'(p);
  endfunction

  function automatic acc_t rnd(input acc_t s);
    acc_t t;
    t = s + (AW'(1) <<< (FRAC_BITS - 1));
    rnd = t >>> FRAC_BITS;
  endfunction

  // Hamilton product term sign table: o[k] = sum sgn * p[i]*q[j]
  // Each output takes four products; index pair and sign per term.
  function automatic logic [1:0] hq_idx(input int k, input int i);
    logic [1:0] r;
    r = 2'd0;
    case (k)
      0: r = 2'(i);
      1: r = (i == 0) ? 2'd1 : (i == 1) ? 2'd0 : (i == 2) ? 2'd3 : 2'd2;
      2: r = (i == 0) ? 2'd2 : (i == 1) ? 2'd3 : (i == 2) ? 2'd0 : 2'd1;
      default: r = (i == 0) ? 2'd3 : (i == 1) ? 2'd2 : (i == 2) ? 2'd1 : 2'd0;
    endcase
    hq_idx = r;
  endfunction

  function automatic logic hq_neg(input int k, input int i);
    logic r;
    r = 1'b0;
    case (k)
      0: r = (i != 0);
      1: r = (i == 3);
      2: r = (i == 1);
      default: r = (i == 2);
    endcase
    hq_neg = r;
  endfunction

  // ======== Stage group A: products of input (mul, rot, scale, dot, norm squares) ========
  // s1: register products; s2: sum + round + sat (norm squared kept unsaturated)
  typedef struct packed {
    logic vld;
    logic [3:0] op;
    quat_t a;
    quat_t b;
  } ctl_t;

  ctl_t s0;
  acc_t [NQ-1:0][NQ-1:0] hp1;   // hamilton a*b terms
  acc_t [NQ-1:0]         sp1;   // a*b_w
  acc_t [NQ-1:0]         dp1;   // a*b
  acc_t [NQ-1:0]         np1;   // squares for the norm

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld <= 1'b0;
    end else begin
      s0.vld <= in_vld;
    end
    s0.op <= in_beat.opcode;
    s0.a  <= {in_beat.a_z, in_beat.a_y, in_beat.a_x, in_beat.a_w};
    s0.b  <= {in_beat.b_z, in_beat.b_y, in_beat.b_x, in_beat.b_w};
  end

  quat_t bh;  // rotate uses (0, v)
  quat_t nq;  // quotient needs the norm of b, all others the norm of a
  always_comb begin
    bh = s0.b;
    if (s0.op == OP_ROT) bh[0] = '0;
    nq = (s0.op == OP_QUOT) ? s0.b : s0.a;
  end

  ctl_t s1;
  always_ff @(posedge clk) begin
    if (rst) s1.vld <= 1'b0;
    else s1.vld <= s0.vld;
    s1.op <= s0.op;
    s1.a  <= s0.a;
    s1.b  <= s0.b;
    for (int k = 0; k < NQ; k++) begin
      for (int i = 0; i < NQ; i++) begin
        hp1[k][i] <= hq_neg(k, i) ? -prod(s0.a[i], bh[hq_idx(k, i)])
                                  :  prod(s0.a[i], bh[hq_idx(k, i)]);
      end
      sp1[k] <= prod(s0.a[k], s0.b[0]);
      dp1[k] <= prod(s0.a[k], s0.b[k]);
      np1[k] <= prod(nq[k], nq[k]);
    end
  end

  // stage 2: sums
  ctl_t s2;
  quat_t ham2;
  logic  ham2_ovf;
  quat_t scl2;
  logic  scl2_ovf;
  q_t    dot2;
  logic  dot2_ovf;
  acc_t  nsq2;        // rounded norm squared, unsaturated (>=0)
  logic [PW-1:0] sos2; // exact sum of squares clamped to 2^64-1

  always_ff @(posedge clk) begin
    acc_t s;
    acc_t d;
    acc_t n;
    logic [PW+1:0] e;
    logic ho;
    logic so;
    if (rst) s2.vld <= 1'b0;
    else s2.vld <= s1.vld;
    s2.op <= s1.op;
    s2.a  <= s1.a;
    s2.b  <= s1.b;
    ho = 1'b0;
    so = 1'b0;
    for (int k = 0; k < NQ; k++) begin
      s = rnd(hp1[k][0] + hp1[k][1] + hp1[k][2] + hp1[k][3]);
      ham2[k] <= sat32(s);
      ho = ho | ovf32(s);
      s = rnd(sp1[k]);
      scl2[k] <= sat32(s);
      so = so | ovf32(s);
    end
    ham2_ovf <= ho;
    scl2_ovf <= so;
    d = rnd(dp1[0] + dp1[1] + dp1[2] + dp1[3]);
    dot2     <= sat32(d);
    dot2_ovf <= ovf32(d);
    n = rnd(np1[0] + np1[1] + np1[2] + np1[3]);
    nsq2 <= n;
    e = (PW+2)'(np1[0]) + (PW+2)'(np1[1]) + (PW+2)'(np1[2]) + (PW+2)'(np1[3]);
    sos2 <= (e[PW+1:PW] != 2'b00) ? {PW{1'b1}} : e[PW-1:0];
  end

  // ======== Stage group B: pipelined sqrt of sos2 (32 steps) ========
  typedef struct packed {
    logic [PW-1:0] rem;
    logic [PW-1:0] rt;
    logic [PW-1:0] bitv;
  } sq_t;

  function automatic sq_t sq_step(input sq_t cur);
    sq_t nxt;
    nxt = cur;
    if (cur.rem >= cur.rt + cur.bitv) begin
      nxt.rem = cur.rem - (cur.rt + cur.bitv);
      nxt.rt  = (cur.rt >> 1) + cur.bitv;
    end else begin
      nxt.rt = cur.rt >> 1;
    end
    nxt.bitv = cur.bitv >> 2;
    return nxt;
  endfunction

  sq_t sq0;
  always_comb begin
    sq0.rem  = sos2;
    sq0.rt   = '0;
    sq0.bitv = PW'(1) << (PW - 2);
  end

  // Each pipeline step processes one bit pair; registered.
  sq_t sqr [1:SQ];
  always_ff @(posedge clk) begin
    sqr[1] <= sq_step(sq0);
    for (int i = 2; i <= SQ; i++) sqr[i] <= sq_step(sqr[i-1]);
  end

  // Delay line of the stage-2 data while sqrt runs.
  localparam int SQD = SQ;
  typedef struct packed {
    ctl_t c;
    quat_t ham;
    logic hov;
    quat_t scl;
    logic sov;
    q_t dot;
    logic dov;
    acc_t nsq;
  } mid_t;

  mid_t md0;
  mid_t md [1:SQD];
  always_comb begin
    md0.c   = s2;
    md0.ham = ham2;
    md0.hov = ham2_ovf;
    md0.scl = scl2;
    md0.sov = scl2_ovf;
    md0.dot = dot2;
    md0.dov = dot2_ovf;
    md0.nsq = nsq2;
  end
  always_ff @(posedge clk) begin
    mid_t t;
    t = md0;
    if (rst) t.c.vld = 1'b0;
    md[1] <= t;
    for (int i = 2; i <= SQD; i++) begin
      t = md[i-1];
      if (rst) t.c.vld = 1'b0;
      md[i] <= t;
    end
  end

  // norm, rounded (s > res -> +1)
  mid_t m3;
  acc_t nrm3;
  assign m3   = md[SQD];
  assign nrm3 = AW'((sqr[SQ].rem > sqr[SQ].rt) ? sqr[SQ].rt + 1'b1 : sqr[SQ].rt);

  // ======== Stage group C: divider, 4 lanes ========
  // Lane numerator = c * 2^F (signed), divisor per op.
  typedef struct packed {
    logic [NW+1:0]  rem;
    logic [NW-1:0]  q;     // shifts in numerator bits / quotient bits
    logic [DVW:0]   d2;    // 2*|d|
    logic           neg;
  } dv_t;

  localparam int DSTEPS = NW;

  function automatic dv_t dv_step(input dv_t cur);
    dv_t nx;
    logic [NW+1:0] r;
    r  = {cur.rem[NW:0], cur.q[NW-1]};
    nx = cur;
    if (r >= (NW+2)'(cur.d2)) begin
      nx.rem = r - (NW+2)'(cur.d2);
      nx.q   = {cur.q[NW-2:0], 1'b1};
    end else begin
      nx.rem = r;
      nx.q   = {cur.q[NW-2:0], 1'b0};
    end
    return nx;
  endfunction

  dv_t [NQ-1:0] dv_in;
  logic         dz3;
  acc_t         dsr;
  always_comb begin
    logic signed [AW-1:0] num;
    logic [AW-1:0] un;
    logic [AW-1:0] ud;
    dsr = '0;
    unique case (m3.c.op)
      OP_SDIV: dsr = AW'(m3.c.b[0]);
      OP_UNIT: dsr = nrm3;
      OP_QUOT, OP_INV, OP_ROT: dsr = m3.nsq;
      default: dsr = AW'(1);
    endcase
    dz3 = (dsr == '0);
    ud  = dsr[AW-1] ? -dsr : dsr;
    for (int k = 0; k < NQ; k++) begin
      q_t c;
      if (m3.c.op == OP_QUOT) c = m3.c.b[k];
      else c = m3.c.a[k];
      if ((m3.c.op == OP_QUOT || m3.c.op == OP_INV || m3.c.op == OP_ROT) && k != 0)
        num = -(AW'(c) <<< FRAC_BITS);
      else
        num = AW'(c) <<< FRAC_BITS;
      un = num[AW-1] ? -num : num;
      // q = (2un + ud) / (2ud): numerator is 2un+ud
      dv_in[k].rem = '0;
      dv_in[k].q   = NW'((un << 1) + ud);
      dv_in[k].d2  = (DVW+1)'(ud << 1);
      dv_in[k].neg = num[AW-1] ^ dsr[AW-1];
    end
  end

  typedef struct packed {
    mid_t m;
    logic dz;
  } dm_t;

  dm_t          dm0;
  dv_t [NQ-1:0] dvr [1:DSTEPS];
  dm_t          dmr [1:DSTEPS];
  always_comb begin
    dm0.m  = m3;
    dm0.dz = dz3;
  end

  always_ff @(posedge clk) begin
    dm_t t;
    for (int k = 0; k < NQ; k++) dvr[1][k] <= dv_step(dv_in[k]);
    t = dm0;
    if (rst) t.m.c.vld = 1'b0;
    dmr[1] <= t;
    for (int i = 2; i <= DSTEPS; i++) begin
      for (int k = 0; k < NQ; k++) dvr[i][k] <= dv_step(dvr[i-1][k]);
      t = dmr[i-1];
      if (rst) t.m.c.vld = 1'b0;
      dmr[i] <= t;
    end
  end

  mid_t d4;
  logic dz4;
  quat_t dq4;
  logic  dq4_ovf;
  assign d4  = dmr[DSTEPS].m;
  assign dz4 = dmr[DSTEPS].dz;
  always_comb begin
    acc_t v;
    dq4_ovf = 1'b0;
    for (int k = 0; k < NQ; k++) begin
      v = AW'({1'b0, dvr[DSTEPS][k].q});
      if (dvr[DSTEPS][k].neg) v = -v;
      dq4[k] = sat32(v);
      dq4_ovf = dq4_ovf | ovf32(v);
    end
  end

  // ======== Stage group D: second/third hamilton (quot, rot) ========
  // r5: stage registers of the divide result
  mid_t m5;
  quat_t inv5;
  logic inv5_ovf;
  logic dz5;
  always_ff @(posedge clk) begin
    mid_t t;
    t = d4;
    if (rst) t.c.vld = 1'b0;
    m5       <= t;
    inv5     <= dq4;
    inv5_ovf <= dq4_ovf;
    dz5      <= dz4;
  end

  // quot: a * inv ; rot: t = a*(0,v) (= m5.ham) then t * inv
  quat_t hl5;
  always_comb begin
    hl5 = (m5.c.op == OP_ROT) ? m5.ham : m5.c.a;
  end

  acc_t [NQ-1:0][NQ-1:0] hp6;
  mid_t m6;
  quat_t inv6;
  logic inv6_ovf;
  logic dz6;
  always_ff @(posedge clk) begin
    mid_t t;
    t = m5;
    if (rst) t.c.vld = 1'b0;
    m6       <= t;
    inv6     <= inv5;
    inv6_ovf <= inv5_ovf;
    dz6      <= dz5;
    for (int k = 0; k < NQ; k++) begin
      for (int i = 0; i < NQ; i++) begin
        hp6[k][i] <= hq_neg(k, i) ? -prod(hl5[i], inv5[hq_idx(k, i)])
                                  :  prod(hl5[i], inv5[hq_idx(k, i)]);
      end
    end
  end

  // Norm result travels in its own delay line from the sqrt output.
  acc_t nrm4 [1:DSTEPS+2];
  always_ff @(posedge clk) begin
    nrm4[1] <= nrm3;
    for (int i = 2; i <= DSTEPS + 2; i++) nrm4[i] <= nrm4[i-1];
  end

  // ======== Final select ========
  qau_out_t fin;
  always_comb begin
    acc_t s;
    acc_t e;
    logic ov;
    logic dz;
    quat_t r;
    quat_t h2;
    logic h2o;
    r  = '0;
    ov = 1'b0;
    dz = 1'b0;
    h2o = 1'b0;
    for (int k = 0; k < NQ; k++) begin
      s = rnd(hp6[k][0] + hp6[k][1] + hp6[k][2] + hp6[k][3]);
      h2[k] = sat32(s);
      h2o = h2o | ovf32(s);
    end
    for (int k = 0; k < NQ; k++) begin
      unique case (m6.c.op)
        OP_ADD: e = AW'(m6.c.a[k]) + AW'(m6.c.b[k]);
        OP_SUB: e = AW'(m6.c.a[k]) - AW'(m6.c.b[k]);
        OP_CONJ: e = (k == 0) ? AW'(m6.c.a[k]) : -AW'(m6.c.a[k]);
        default: e = -AW'(m6.c.a[k]);
      endcase
      if (m6.c.op == OP_ADD || m6.c.op == OP_SUB || m6.c.op == OP_NEG ||
          m6.c.op == OP_CONJ) begin
        r[k] = sat32(e);
        ov = ov | ovf32(e);
      end
    end
    case (m6.c.op)
      OP_MUL: begin
        r = m6.ham;
        ov = m6.hov;
      end
      OP_SCL: begin
        r = m6.scl;
        ov = m6.sov;
      end
      OP_DOT: begin
        r[0] = m6.dot;
        ov = m6.dov;
      end
      OP_NSQ: begin
        r[0] = sat32(m6.nsq);
        ov = ovf32(m6.nsq);
      end
      OP_NORM: begin
        r[0] = sat32(nrm4[DSTEPS+2]);
        ov = ovf32(nrm4[DSTEPS+2]);
      end
      OP_QUOT: begin
        dz = dz6;
        r = h2;
        ov = inv6_ovf | h2o;
      end
      OP_INV, OP_SDIV, OP_UNIT: begin
        dz = dz6;
        r = inv6;
        ov = inv6_ovf;
      end
      OP_ROT: begin
        dz = dz6;
        r = h2;
        r[0] = '0;
        ov = inv6_ovf | m6.hov | h2o;
      end
      default: ;
    endcase
    if (dz) r = '0;
    fin.res_w  = r[0];
    fin.res_x  = r[1];
    fin.res_y  = r[2];
    fin.res_z  = r[3];
    fin.status = dz ? ST_DZ : (ov ? ST_OVF : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= m6.c.vld;
    out_beat <= fin;
  end

  // A divide-by-zero status only comes from dividing opcodes.
  a_dz_op: assert property (@(posedge clk) disable iff (rst)
    (m6.c.vld && fin.status == ST_DZ) |-> (m6.c.op == OP_QUOT || m6.c.op == OP_SDIV ||
      m6.c.op == OP_INV || m6.c.op == OP_UNIT || m6.c.op == OP_ROT))
    else $error("dz on non-divide op");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_beat.status == ST_DZ) |-> (out_beat.res_w == '0 &&
      out_beat.res_x == '0 && out_beat.res_y == '0 && out_beat.res_z == '0))
    else $error("dz result not zero");
  a_rot_w: assert property (@(posedge clk) disable iff (rst)
    (m6.c.vld && m6.c.op == OP_ROT) |=> (out_beat.res_w == '0))
    else $error("rotate real part nonzero");

endmodule
`default_nettype wire
